// ===== rtl/core/bmhq_pkg.sv =====
// Shared types and codes for the binary min-heap queue.
// Used by bmhq_engine and binary_min_heap_queue_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

  localparam int NODE_W  = 32;
  localparam int PRIO_W  = 32;
  localparam int FILL_W  = 11;
  localparam int STAT_W  = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  // One heap slot as it sits in the RAM.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [NODE_W-1:0] node;
  } bmhq_entry_t;

  // Finished operation handed from the engine to the output register.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [NODE_W-1:0] node;
    logic [PRIO_W-1:0] prio;
    logic [FILL_W-1:0] fill;
  } bmhq_result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_UP,
    S_PUSH_CMP,
    S_POP_ROOT,
    S_POP_LAST,
    S_DOWN_L,
    S_DOWN_R,
    S_DOWN_CMP,
    S_RESULT
  } bmhq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/binary_min_heap_queue_unit.sv =====
// Binary min-heap priority queue: push/pop of (node, priority) entries.
// A push climbs from the next free slot, reading and comparing the parent at each level; a
// pop reads the root, moves the last entry to the root and sinks it, reading both
// children and comparing at each level, until it settles or reaches a leaf. A refused push
// or empty pop goes straight to the result. The walk over the heap RAM (up to log2(DEPTH)
// levels) sets the time taken; one item at a time, the next taken in the cycle after the
// result reaches the output register. Reset empties the heap; RAM is not cleared.
// Depends on bmhq_pkg and bmhq_engine.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue_unit #(
  parameter int DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] node_in, [63:32] priority_in
  input  wire logic [0:0]  in_tuser,   // [0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [31:0] node_out, [63:32] priority_out,
                                       // [74:64] fill_level, [79:75] zero
  output logic [1:0]       out_tuser   // [1:0] status
);

  logic                   res_valid, res_ready;
  bmhq_pkg::bmhq_result_t res;
  bmhq_pkg::bmhq_result_t out_r;
  logic                   out_valid_r;

  bmhq_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser[0]),
    .in_node   (in_tdata[31:0]),
    .in_prio   (in_tdata[63:32]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // load when the output stage is empty or draining this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {5'b0, out_r.fill, out_r.prio, out_r.node};

endmodule

`default_nettype wire

// ===== rtl/core/bmhq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/bmhq_engine.sv =====
// Heap sequencer: push sift-up and pop sift-down over the heap RAM.
// Depends on bmhq_pkg and bmhq_ram.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_engine #(
  parameter int DEPTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_op,
  input  wire logic [bmhq_pkg::NODE_W-1:0]  in_node,
  input  wire logic [bmhq_pkg::PRIO_W-1:0]  in_prio,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output bmhq_pkg::bmhq_result_t            res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 2;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  bmhq_pkg::bmhq_state_t state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  bmhq_pkg::bmhq_entry_t ent_r, ent_nxt;
  bmhq_pkg::bmhq_entry_t lft_r, lft_nxt;
  logic                  has_r_r, has_r_nxt;
  logic [bmhq_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [bmhq_pkg::NODE_W-1:0] onode_r, onode_nxt;
  logic [bmhq_pkg::PRIO_W-1:0] oprio_r, oprio_nxt;

  // RAM port controls
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  bmhq_pkg::bmhq_entry_t wr_ent, rd_ent;
  logic [$bits(bmhq_pkg::bmhq_entry_t)-1:0] rd_bits;

  // Index arithmetic
  logic [AW-1:0] idx_m1, up, up_m1, upup;
  logic [XW-1:0] count_x, lc_x, rc_x, nlc_x;
  logic          lc_in, rc_in, nlc_in;
  logic          par_le, left_lt, right_lt, stay;
  bmhq_pkg::bmhq_entry_t mid, pick;
  logic [AW-1:0] pick_idx;
  logic [CW+bmhq_pkg::FILL_W-1:0] fill_x;

  bmhq_ram #(
    .WIDTH ($bits(bmhq_pkg::bmhq_entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  assign rd_ent = rd_bits;

  assign idx_m1 = idx_r - AW'(1);
  assign up     = idx_m1 >> 1;
  assign up_m1  = up - AW'(1);
  assign upup   = up_m1 >> 1;

  assign count_x = {{(XW-CW){1'b0}}, count_r};
  assign lc_x    = {1'b0, idx_r, 1'b1};
  assign rc_x    = lc_x + XW'(1);
  assign lc_in   = lc_x < count_x;
  assign rc_in   = rc_x < count_x;

  // parent holds its place when not strictly greater
  assign par_le = rd_ent.prio <= ent_r.prio;

  // left child wins ties; right must be strictly smaller than the running best
  assign left_lt  = lft_r.prio < ent_r.prio;
  assign mid      = left_lt ? lft_r : ent_r;
  assign right_lt = has_r_r && (rd_ent.prio < mid.prio);
  assign pick     = right_lt ? rd_ent : lft_r;
  assign pick_idx = right_lt ? rc_x[AW-1:0] : lc_x[AW-1:0];
  assign stay     = !left_lt && !right_lt;
  assign nlc_x    = {1'b0, pick_idx, 1'b1};
  assign nlc_in   = nlc_x < count_x;

  assign fill_x = {{bmhq_pkg::FILL_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmhq_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    ent_r    <= ent_nxt;
    lft_r    <= lft_nxt;
    has_r_r  <= has_r_nxt;
    status_r <= status_nxt;
    onode_r  <= onode_nxt;
    oprio_r  <= oprio_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmhq_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_op == bmhq_pkg::OP_PUSH) begin
            state_nxt = (count_r == FULL_COUNT) ? bmhq_pkg::S_RESULT : bmhq_pkg::S_PUSH_UP;
          end else begin
            state_nxt = (count_r == '0) ? bmhq_pkg::S_RESULT : bmhq_pkg::S_POP_ROOT;
          end
        end
      end
      bmhq_pkg::S_PUSH_UP: begin
        state_nxt = (idx_r == '0) ? bmhq_pkg::S_RESULT : bmhq_pkg::S_PUSH_CMP;
      end
      bmhq_pkg::S_PUSH_CMP: begin
        if (par_le) begin
          state_nxt = bmhq_pkg::S_RESULT;
        end else if (up == '0) begin
          state_nxt = bmhq_pkg::S_PUSH_UP;
        end else begin
          state_nxt = bmhq_pkg::S_PUSH_CMP;
        end
      end
      bmhq_pkg::S_POP_ROOT: begin
        state_nxt = (count_r == '0) ? bmhq_pkg::S_RESULT : bmhq_pkg::S_POP_LAST;
      end
      bmhq_pkg::S_POP_LAST: begin
        state_nxt = bmhq_pkg::S_DOWN_L;
      end
      bmhq_pkg::S_DOWN_L: begin
        state_nxt = lc_in ? bmhq_pkg::S_DOWN_R : bmhq_pkg::S_RESULT;
      end
      bmhq_pkg::S_DOWN_R: begin
        state_nxt = bmhq_pkg::S_DOWN_CMP;
      end
      bmhq_pkg::S_DOWN_CMP: begin
        if (stay) begin
          state_nxt = bmhq_pkg::S_RESULT;
        end else if (nlc_in) begin
          state_nxt = bmhq_pkg::S_DOWN_R;
        end else begin
          state_nxt = bmhq_pkg::S_DOWN_L;
        end
      end
      bmhq_pkg::S_RESULT: begin
        if (res_ready) begin
          state_nxt = bmhq_pkg::S_IDLE;
        end
      end
      default: state_nxt = bmhq_pkg::S_IDLE;
    endcase
  end

  // Outputs, RAM accesses and datapath updates
  always_comb begin
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_ent     = ent_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    ent_nxt    = ent_r;
    lft_nxt    = lft_r;
    has_r_nxt  = has_r_r;
    status_nxt = status_r;
    onode_nxt  = onode_r;
    oprio_nxt  = oprio_r;
    case (state_r)
      bmhq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          status_nxt = bmhq_pkg::STATUS_OK;
          onode_nxt  = '0;
          oprio_nxt  = '0;
          if (in_op == bmhq_pkg::OP_PUSH) begin
            if (count_r == FULL_COUNT) begin
              status_nxt = bmhq_pkg::STATUS_FULL;
            end else begin
              ent_nxt.node = in_node;
              ent_nxt.prio = in_prio;
              idx_nxt      = count_r[AW-1:0];
              count_nxt    = count_r + CW'(1);
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = bmhq_pkg::STATUS_EMPTY;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              count_nxt = count_r - CW'(1);
            end
          end
        end
      end
      bmhq_pkg::S_PUSH_UP: begin
        if (idx_r == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = up;
        end
      end
      bmhq_pkg::S_PUSH_CMP: begin
        wr_en = 1'b1;
        if (!par_le) begin
          // move the parent down into the hole and climb
          wr_ent  = rd_ent;
          idx_nxt = up;
          if (up != '0) begin
            rd_en   = 1'b1;
            rd_addr = upup;
          end
        end
      end
      bmhq_pkg::S_POP_ROOT: begin
        onode_nxt = rd_ent.node;
        oprio_nxt = rd_ent.prio;
        if (count_r != '0) begin
          rd_en   = 1'b1;
          rd_addr = count_r[AW-1:0];
        end
      end
      bmhq_pkg::S_POP_LAST: begin
        ent_nxt = rd_ent;
        idx_nxt = '0;
      end
      bmhq_pkg::S_DOWN_L: begin
        if (lc_in) begin
          rd_en   = 1'b1;
          rd_addr = lc_x[AW-1:0];
        end else begin
          wr_en = 1'b1;
        end
      end
      bmhq_pkg::S_DOWN_R: begin
        lft_nxt   = rd_ent;
        has_r_nxt = rc_in;
        if (rc_in) begin
          rd_en   = 1'b1;
          rd_addr = rc_x[AW-1:0];
        end
      end
      bmhq_pkg::S_DOWN_CMP: begin
        wr_en = 1'b1;
        if (!stay) begin
          // lift the smaller child into the hole and descend
          wr_ent  = pick;
          idx_nxt = pick_idx;
          if (nlc_in) begin
            rd_en   = 1'b1;
            rd_addr = nlc_x[AW-1:0];
          end
        end
      end
      bmhq_pkg::S_RESULT: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign res.status = status_r;
  assign res.node   = onode_r;
  assign res.prio   = oprio_r;
  assign res.fill   = fill_x[bmhq_pkg::FILL_W-1:0];

endmodule

`default_nettype wire

// ===== tb/binary_min_heap_queue_unit_test.sv =====
// Self-checking bench for binary_min_heap_queue_unit: push/pop streams against a
// heap predictor, with random stalls on both stream sides.
// Depends on bmhq_pkg and the unit RTL.
`timescale 1ns / 1ps

module binary_min_heap_queue_unit_test;

  localparam int DEPTH = 1024;

  typedef struct packed {
    logic                        op;
    logic [bmhq_pkg::NODE_W-1:0] node;
    logic [bmhq_pkg::PRIO_W-1:0] prio;
  } heap_req_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // [31:0] node_in, [63:32] priority_in
  logic [0:0]  in_tuser   = '0;   // [0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;         // [31:0] node_out, [63:32] priority_out, [74:64] fill_level
  logic [1:0]  out_tuser;         // [1:0] status

  binary_min_heap_queue_unit #(.DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  heap_req_t              op_backlog[$];
  bmhq_pkg::bmhq_result_t heap_results_due[$];
  int                     op_total;
  int                     ops_sent;
  int                     ops_accepted;
  int                     results_seen;
  int                     error_count;
  int unsigned            gen_fill;

  // Predicted heap contents
  logic [bmhq_pkg::NODE_W-1:0] heap_node [DEPTH];
  logic [bmhq_pkg::PRIO_W-1:0] heap_prio [DEPTH];
  int unsigned                 heap_count;

  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    logic [bmhq_pkg::NODE_W-1:0] tn;
    logic [bmhq_pkg::PRIO_W-1:0] tp;
    tn           = heap_node[a];
    tp           = heap_prio[a];
    heap_node[a] = heap_node[b];
    heap_prio[a] = heap_prio[b];
    heap_node[b] = tn;
    heap_prio[b] = tp;
  endfunction

  function automatic bmhq_pkg::bmhq_result_t heap_model_apply(input heap_req_t req);
    bmhq_pkg::bmhq_result_t res;
    int unsigned  idx;
    int unsigned  up;
    int unsigned  lc;
    int unsigned  rc;
    int unsigned  best;
    logic         done;
    res        = '0;
    res.status = bmhq_pkg::STATUS_OK;
    done       = 1'b0;
    if (req.op == bmhq_pkg::OP_PUSH) begin
      if (heap_count >= DEPTH) begin
        res.status = bmhq_pkg::STATUS_FULL;
      end else begin
        idx = heap_count;
        heap_count++;
        heap_node[idx] = req.node;
        heap_prio[idx] = req.prio;
        // climb while the parent is strictly greater
        while (idx > 0 && !done) begin
          up = (idx - 1) / 2;
          if (heap_prio[up] <= heap_prio[idx]) begin
            done = 1'b1;
          end else begin
            swap_slots(up, idx);
            idx = up;
          end
        end
      end
    end else begin
      if (heap_count == 0) begin
        res.status = bmhq_pkg::STATUS_EMPTY;
      end else begin
        res.node = heap_node[0];
        res.prio = heap_prio[0];
        heap_count--;
        if (heap_count != 0) begin
          heap_node[0] = heap_node[heap_count];
          heap_prio[0] = heap_prio[heap_count];
          idx = 0;
          // sink toward the smaller child, left one on ties
          while (!done) begin
            lc   = idx * 2 + 1;
            rc   = lc + 1;
            best = idx;
            if (lc < heap_count && heap_prio[lc] < heap_prio[best]) best = lc;
            if (rc < heap_count && heap_prio[rc] < heap_prio[best]) best = rc;
            if (best == idx) begin
              done = 1'b1;
            end else begin
              swap_slots(idx, best);
              idx = best;
            end
          end
        end
      end
    end
    res.fill = bmhq_pkg::FILL_W'(heap_count);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH result %0d %s: got %h, want %h", results_seen, what, got, want);
    error_count++;
  endtask

  // Stimulus generation; gen_fill tracks the heap size the queue will produce
  task automatic add_op(input logic op, input logic [31:0] node, input logic [31:0] prio);
    heap_req_t req;
    req.op   = op;
    req.node = node;
    req.prio = prio;
    op_backlog.push_back(req);
    if (op == bmhq_pkg::OP_PUSH && gen_fill < DEPTH) gen_fill++;
    if (op == bmhq_pkg::OP_POP && gen_fill > 0) gen_fill--;
  endtask

  function automatic logic [31:0] pick_prio();
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom_range(15);
      5:       return $urandom_range(32'h0000_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_node();
    case ($urandom_range(19))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random(input int push_pct);
    if ($urandom_range(99) < push_pct)
      add_op(bmhq_pkg::OP_PUSH, pick_node(), pick_prio());
    else
      add_op(bmhq_pkg::OP_POP, $urandom, $urandom);
  endtask

  // Driver: present the next backlog entry, predict on each transfer
  always @(posedge clk) begin : drive_proc
    heap_req_t req;
    logic      quiet;
    quiet = (ops_sent >= 900 && ops_sent < 1300);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        req.op   = in_tuser[0];
        req.node = in_tdata[31:0];
        req.prio = in_tdata[63:32];
        heap_results_due.push_back(heap_model_apply(req));
        ops_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (op_backlog.size() != 0 && (quiet || $urandom_range(99) >= 7)) begin
          req = op_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {req.prio, req.node};
          in_tuser  <= req.op;
          ops_sent++;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_proc
    bmhq_pkg::bmhq_result_t want;
    logic                   quiet;
    quiet = (results_seen >= 900 && results_seen < 1300);
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (heap_results_due.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], 32'h0);
        end else begin
          want = heap_results_due.pop_front();
          if (out_tuser !== want.status)
            report_mismatch("status", 32'(out_tuser), 32'(want.status));
          if (out_tdata[31:0] !== want.node)
            report_mismatch("node", out_tdata[31:0], want.node);
          if (out_tdata[63:32] !== want.prio)
            report_mismatch("priority", out_tdata[63:32], want.prio);
          if (out_tdata[74:64] !== want.fill)
            report_mismatch("fill level", 32'(out_tdata[74:64]), 32'(want.fill));
          if (out_tdata[79:75] !== 5'd0)
            report_mismatch("pad bits", 32'(out_tdata[79:75]), 32'h0);
        end
        results_seen++;
      end
      out_tready <= quiet || ($urandom_range(99) >= 7);
    end
  end

  initial begin
    int n;
    op_total     = 0;
    ops_sent     = 0;
    ops_accepted = 0;
    results_seen = 0;
    error_count  = 0;
    gen_fill     = 0;
    heap_count   = 0;

    // directed: empty pop, extremes, ties, root replacement
    add_op(bmhq_pkg::OP_POP,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(bmhq_pkg::OP_PUSH, 32'h0000_0000, 32'h0000_0000);
    add_op(bmhq_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(bmhq_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'h0000_0000);
    add_op(bmhq_pkg::OP_PUSH, 32'h1234_5678, 32'h0000_0005);
    add_op(bmhq_pkg::OP_PUSH, 32'h0000_0011, 32'h0000_0005);
    add_op(bmhq_pkg::OP_PUSH, 32'h0000_0022, 32'h0000_0003);
    add_op(bmhq_pkg::OP_PUSH, 32'h0000_0033, 32'h8000_0000);
    add_op(bmhq_pkg::OP_PUSH, 32'h0000_0044, 32'h7FFF_FFFF);
    add_op(bmhq_pkg::OP_POP,  32'h0, 32'h0);
    add_op(bmhq_pkg::OP_POP,  32'h0, 32'h0);
    add_op(bmhq_pkg::OP_POP,  32'h0, 32'h0);
    add_op(bmhq_pkg::OP_PUSH, 32'hAAAA_5555, 32'h0000_0004);
    add_op(bmhq_pkg::OP_POP,  32'h0, 32'h0);
    add_op(bmhq_pkg::OP_POP,  32'h0, 32'h0);
    add_op(bmhq_pkg::OP_POP,  32'h0, 32'h0);
    add_op(bmhq_pkg::OP_POP,  32'h0, 32'h0);
    add_op(bmhq_pkg::OP_POP,  32'h0, 32'h0);
    add_op(bmhq_pkg::OP_POP,  32'h0, 32'h0);
    add_op(bmhq_pkg::OP_POP,  32'h0, 32'h0);

    // mixed traffic near the top of the tree
    for (n = 0; n < 150; n++) add_random(55);
    // fill to capacity, then push into the full heap
    while (gen_fill < DEPTH) add_random(98);
    add_op(bmhq_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'h0000_0000);
    add_op(bmhq_pkg::OP_PUSH, 32'h0000_0000, 32'hFFFF_FFFF);
    for (n = 0; n < 3; n++) add_op(bmhq_pkg::OP_PUSH, $urandom, $urandom);
    add_op(bmhq_pkg::OP_POP, 32'h0, 32'h0);
    add_op(bmhq_pkg::OP_PUSH, pick_node(), pick_prio());
    add_op(bmhq_pkg::OP_PUSH, pick_node(), pick_prio());
    // drain through deep sift-downs
    while (gen_fill > 700) add_random(10);
    add_op(bmhq_pkg::OP_POP, 32'h0, 32'h0);
    add_op(bmhq_pkg::OP_POP, 32'h0, 32'h0);
    for (n = 0; n < 100; n++) add_random(50);
    op_total = op_backlog.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (ops_accepted == op_total);
    while (heap_results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    #(12 * 1_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
